FILE: src/imufps_pkg.sv
// Package for the IMU frame parser and scaler: frame layout, channel codes,
// register map and reset values. Used by imu_frame_parser_scaler.
package imufps_pkg;

	localparam int FRAME_BYTES_DEF     = 34;
	localparam int SYNC_RUN_LENGTH_DEF = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	localparam logic [5:0] POS_MSG_ID    = 6'd0;
	localparam logic [5:0] POS_TIMER_HI  = 6'd3;
	localparam logic [5:0] POS_TIMER_LO  = 6'd4;
	localparam logic [5:0] POS_CHAN_LO   = 6'd9;
	localparam logic [5:0] POS_CHAN_HI   = 6'd32;
	localparam logic [4:0] CHAN_POS_BIAS = 5'd3;

	localparam logic [3:0] CH_MSG_ID  = 4'd0;
	localparam logic [3:0] CH_TIMER   = 4'd1;
	localparam logic [3:0] CH_GYRO_Z  = 4'd4;
	localparam logic [3:0] CH_ACCEL_Z = 4'd7;
	localparam logic [3:0] CH_MAG_Z   = 4'd10;
	localparam logic [3:0] CH_TEMP_Z  = 4'd13;

	localparam logic [2:0] REG_GYRO_GAIN   = 3'd0;
	localparam logic [2:0] REG_ACCEL_GAIN  = 3'd1;
	localparam logic [2:0] REG_MAG_GAIN    = 3'd2;
	localparam logic [2:0] REG_TEMP_GAIN   = 3'd3;
	localparam logic [2:0] REG_TEMP_OFFSET = 3'd4;

	localparam logic [19:0]        GYRO_GAIN_RST   = 20'd230400;
	localparam logic [19:0]        ACCEL_GAIN_RST  = 20'd1536;
	localparam logic [19:0]        MAG_GAIN_RST    = 20'd730;
	localparam logic [19:0]        TEMP_GAIN_RST   = 20'd304762;
	localparam logic signed [23:0] TEMP_OFFSET_RST = 24'sd1638400;

	localparam logic signed [29:0] SCALED_MAX = 30'sd67108863;
	localparam logic signed [29:0] SCALED_MIN = -30'sd67108864;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_GYRO,
		KIND_ACCEL,
		KIND_MAG,
		KIND_TEMP
	} kind_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [15:0] word;
		kind_t       kind;
	} stage_t;

endpackage

FILE: src/imu_frame_parser_scaler.sv
// IMU frame parser and scaler: sync hunt, frame capture and Q16 scaling.
// Depends on imufps_pkg.
//
//   channel   dir  width  fields (lowest bit first)
//   s_*       in   8      tdata: rx_byte
//   m_*       out  48     tdata: raw_word[15:0], scaled_value[42:16]; tuser: channel;
//                         tlast: frame_last
//   APB       in   32     gyro_gain, accel_gain, mag_gain, temp_gain, temp_offset
//
// One byte per cycle is accepted unless both stages are full and the output stalls.
// Stage 1 parses the byte, stage 2 does the 16x21 multiply, shift, offset and clamp.
// Reset clears the parser and the pipeline valid bits and loads register defaults.
// A stalled output holds both stages; s_tready drops only when both are full.
module imu_frame_parser_scaler
	import imufps_pkg::*;
#(
	parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
	parameter int SYNC_RUN_LENGTH = SYNC_RUN_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // raw_word, scaled_value, zero pad
	output logic [3:0]  m_tuser,   // channel
	output logic        m_tlast,   // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] SYNC_LEN   = 3'(SYNC_RUN_LENGTH);
	localparam logic [6:0] FRAME_LEN  = 7'(FRAME_BYTES);

	logic [19:0]        gyro_gain_q, accel_gain_q, mag_gain_q, temp_gain_q;
	logic signed [23:0] temp_offset_q;

	logic [2:0] sync_run_q;
	logic       in_frame_q;
	logic [5:0] pos_q;
	logic [7:0] held_q;

	logic   valid_s1;
	stage_t data_s1;
	logic   valid_s2;
	logic [47:0] tdata_s2;
	logic [3:0]  tuser_s2;
	logic        tlast_s2;

	logic   out_free, advance_s1, accept;
	logic   emit;
	stage_t item;
	logic [2:0] run_next;
	logic [6:0] pos_next;
	logic [4:0] chan_wide;

	logic [19:0]        gain_sel;
	logic signed [15:0] raw_s;
	logic signed [20:0] gain_s;
	logic signed [36:0] prod;
	logic signed [29:0] sum;
	logic signed [29:0] offset_ext;
	logic signed [26:0] scaled;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q   <= GYRO_GAIN_RST;
			accel_gain_q  <= ACCEL_GAIN_RST;
			mag_gain_q    <= MAG_GAIN_RST;
			temp_gain_q   <= TEMP_GAIN_RST;
			temp_offset_q <= TEMP_OFFSET_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:2])
				REG_GYRO_GAIN:   gyro_gain_q   <= pwdata[19:0];
				REG_ACCEL_GAIN:  accel_gain_q  <= pwdata[19:0];
				REG_MAG_GAIN:    mag_gain_q    <= pwdata[19:0];
				REG_TEMP_GAIN:   temp_gain_q   <= pwdata[19:0];
				REG_TEMP_OFFSET: temp_offset_q <= $signed(pwdata[23:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_GYRO_GAIN:   prdata = {12'b0, gyro_gain_q};
			REG_ACCEL_GAIN:  prdata = {12'b0, accel_gain_q};
			REG_MAG_GAIN:    prdata = {12'b0, mag_gain_q};
			REG_TEMP_GAIN:   prdata = {12'b0, temp_gain_q};
			REG_TEMP_OFFSET: prdata = {{8{temp_offset_q[23]}}, temp_offset_q};
			default:         prdata = 32'b0;
		endcase
	end

	// handshake
	assign out_free   = !valid_s2 || m_tready;
	assign advance_s1 = valid_s1 && out_free;
	assign s_tready   = !valid_s1 || out_free;
	assign accept     = s_tvalid && s_tready;

	// stage 1: parse
	assign run_next  = sync_run_q + 3'd1;
	assign pos_next  = {1'b0, pos_q} + 7'd1;
	assign chan_wide = pos_q[5:1] - CHAN_POS_BIAS;

	always_comb begin
		emit         = 1'b0;
		item.channel = CH_MSG_ID;
		item.word    = {8'b0, s_tdata};
		item.kind    = KIND_PLAIN;
		if (in_frame_q) begin
			if (pos_q == POS_MSG_ID) begin
				emit = 1'b1;
			end else if (pos_q == POS_TIMER_LO) begin
				emit         = 1'b1;
				item.channel = CH_TIMER;
				item.word    = {held_q, s_tdata};
			end else if (pos_q >= POS_CHAN_LO && pos_q <= POS_CHAN_HI && !pos_q[0]) begin
				emit         = 1'b1;
				item.channel = chan_wide[3:0];
				item.word    = {held_q, s_tdata};
				priority if (item.channel <= CH_GYRO_Z)  item.kind = KIND_GYRO;
				else if (item.channel <= CH_ACCEL_Z)     item.kind = KIND_ACCEL;
				else if (item.channel <= CH_MAG_Z)       item.kind = KIND_MAG;
				else                                     item.kind = KIND_TEMP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_run_q <= 3'd0;
			in_frame_q <= 1'b0;
			pos_q      <= 6'd0;
			held_q     <= 8'd0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (s_tdata == SYNC_BYTE) begin
					if (run_next >= SYNC_LEN) begin
						in_frame_q <= 1'b1;
						pos_q      <= 6'd0;
						sync_run_q <= 3'd0;
					end else begin
						sync_run_q <= run_next;
					end
				end else begin
					sync_run_q <= 3'd0;
				end
			end else begin
				if (pos_q == POS_TIMER_HI ||
				    (pos_q >= POS_CHAN_LO && pos_q <= POS_CHAN_HI && pos_q[0])) begin
					held_q <= s_tdata;
				end
				if (pos_next >= FRAME_LEN) begin
					in_frame_q <= 1'b0;
					pos_q      <= 6'd0;
				end else begin
					pos_q <= pos_next[5:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			data_s1 <= item;
		end
	end

	// stage 2: scale
	always_comb begin
		unique case (data_s1.kind)
			KIND_GYRO:  gain_sel = gyro_gain_q;
			KIND_ACCEL: gain_sel = accel_gain_q;
			KIND_MAG:   gain_sel = mag_gain_q;
			KIND_TEMP:  gain_sel = temp_gain_q;
			default:    gain_sel = 20'd0;
		endcase
	end

	assign raw_s      = $signed(data_s1.word);
	assign gain_s     = $signed({1'b0, gain_sel});
	assign prod       = raw_s * gain_s;
	assign offset_ext = (data_s1.kind == KIND_TEMP) ?
	                    {{6{temp_offset_q[23]}}, temp_offset_q} : 30'sd0;
	assign sum        = {prod[36], prod[36:8]} + offset_ext;

	always_comb begin
		if (data_s1.kind == KIND_PLAIN)
			scaled = $signed({11'b0, data_s1.word});
		else if (sum > SCALED_MAX)
			scaled = SCALED_MAX[26:0];
		else if (sum < SCALED_MIN)
			scaled = SCALED_MIN[26:0];
		else
			scaled = sum[26:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			tdata_s2 <= {5'b0, scaled, data_s1.word};
			tuser_s2 <= data_s1.channel;
			tlast_s2 <= (data_s1.channel == CH_TEMP_Z);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;
	assign m_tuser  = tuser_s2;
	assign m_tlast  = tlast_s2;

`ifndef SYNTHESIS
	a_last_on_temp_z: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == CH_TEMP_Z)
		else $error("frame_last on a channel other than temperature z");

	a_hunt_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> pos_q == 6'd0)
		else $error("byte position not cleared while hunting");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(data_s1))
		else $error("stage 1 item lost while output stalled");

	a_plain_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == CH_MSG_ID || m_tuser == CH_TIMER) |->
		m_tdata[42:16] == {11'b0, m_tdata[15:0]})
		else $error("id or timer value not equal to raw word");

	a_no_sync_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> sync_run_q == 3'd0)
		else $error("sync run counting inside a frame");
`endif

endmodule

FILE: tb/imu_frame_parser_scaler_chk.sv
// Checker for imu_frame_parser_scaler: watches the byte, result and register ports,
// tracks sync hunt, frame position and Q16 scaling, and compares each result transfer.
// Depends on imufps_pkg.
module imu_frame_parser_scaler_chk
	import imufps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // raw_word[15:0], scaled_value[42:16], zero pad
	input  logic [3:0]  m_tuser,   // channel
	input  logic        m_tlast,   // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_cnt,
	output int          due_cnt
);

	typedef struct packed {
		logic [3:0]         channel;
		logic [15:0]        raw_word;
		logic signed [26:0] scaled_value;
		logic               frame_last;
	} reading_t;

	reading_t readings_due[$];
	reading_t got;
	reading_t want;

	logic [19:0]        gyro_k;
	logic [19:0]        accel_k;
	logic [19:0]        mag_k;
	logic [19:0]        temp_k;
	logic signed [23:0] temp_bias;

	logic [2:0]         sync_cnt;
	logic               framing;
	logic [5:0]         pos;
	logic [7:0]         hi_byte;

	logic [15:0]        word;
	logic signed [15:0] raw;
	logic [3:0]         ch;
	kind_t              kind;
	logic [19:0]        gain;
	longint             scaled;
	int                 errs;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_k    = GYRO_GAIN_RST;
			accel_k   = ACCEL_GAIN_RST;
			mag_k     = MAG_GAIN_RST;
			temp_k    = TEMP_GAIN_RST;
			temp_bias = TEMP_OFFSET_RST;
			sync_cnt  = '0;
			framing   = 1'b0;
			pos       = '0;
			hi_byte   = '0;
			readings_due.delete();
			errs      = 0;
			fail_cnt <= 0;
			due_cnt  <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_GYRO_GAIN:   gyro_k    = pwdata[19:0];
					REG_ACCEL_GAIN:  accel_k   = pwdata[19:0];
					REG_MAG_GAIN:    mag_k     = pwdata[19:0];
					REG_TEMP_GAIN:   temp_k    = pwdata[19:0];
					REG_TEMP_OFFSET: temp_bias = pwdata[23:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				if (!framing) begin
					if (s_tdata == SYNC_BYTE) begin
						sync_cnt = sync_cnt + 3'd1;
						if (sync_cnt >= SYNC_RUN_LENGTH_DEF) begin
							framing  = 1'b1;
							pos      = '0;
							sync_cnt = '0;
						end
					end else begin
						sync_cnt = '0;
					end
				end else begin
					if (pos == POS_MSG_ID) begin
						readings_due.push_back('{CH_MSG_ID, {8'h00, s_tdata},
							27'(s_tdata), 1'b0});
					end else if (pos == POS_TIMER_HI) begin
						hi_byte = s_tdata;
					end else if (pos == POS_TIMER_LO) begin
						word = {hi_byte, s_tdata};
						readings_due.push_back('{CH_TIMER, word, 27'(word), 1'b0});
					end else if (pos >= POS_CHAN_LO && pos <= POS_CHAN_HI) begin
						if (pos[0]) begin
							hi_byte = s_tdata;
						end else begin
							word = {hi_byte, s_tdata};
							raw  = word;
							ch   = 4'((pos >> 1) - 6'(CHAN_POS_BIAS));
							if (ch <= CH_GYRO_Z) kind = KIND_GYRO;
							else if (ch <= CH_ACCEL_Z) kind = KIND_ACCEL;
							else if (ch <= CH_MAG_Z) kind = KIND_MAG;
							else kind = KIND_TEMP;
							case (kind)
								KIND_GYRO:  gain = gyro_k;
								KIND_ACCEL: gain = accel_k;
								KIND_MAG:   gain = mag_k;
								default:    gain = temp_k;
							endcase
							scaled = raw * $signed({1'b0, gain});
							scaled = scaled >>> 8;
							if (kind == KIND_TEMP)
								scaled = scaled + temp_bias;
							if (scaled > SCALED_MAX)
								scaled = SCALED_MAX;
							else if (scaled < SCALED_MIN)
								scaled = SCALED_MIN;
							readings_due.push_back('{ch, word, scaled[26:0],
								ch == CH_TEMP_Z});
						end
					end
					if (pos + 7'd1 >= FRAME_BYTES_DEF) begin
						framing = 1'b0;
						pos     = '0;
					end else begin
						pos = pos + 6'd1;
					end
				end
			end

			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[15:0], m_tdata[42:16], m_tlast};
				if (readings_due.size() == 0) begin
					errs++;
					$error("result on channel %0d with no expectation waiting", got.channel);
				end else begin
					want = readings_due.pop_front();
					if (got.channel !== want.channel) begin
						errs++;
						$error("channel: expected %0d, actual %0d", want.channel, got.channel);
					end
					if (got.raw_word !== want.raw_word) begin
						errs++;
						$error("raw_word: expected %h, actual %h", want.raw_word, got.raw_word);
					end
					if (got.scaled_value !== want.scaled_value) begin
						errs++;
						$error("scaled_value: expected %0d, actual %0d",
							want.scaled_value, got.scaled_value);
					end
					if (got.frame_last !== want.frame_last) begin
						errs++;
						$error("frame_last: expected %0b, actual %0b",
							want.frame_last, got.frame_last);
					end
				end
			end

			fail_cnt <= errs;
			due_cnt  <= readings_due.size();
		end
	end

endmodule

FILE: tb/imu_frame_parser_scaler_tb.sv
// Testbench top for imu_frame_parser_scaler: drives bytes, register writes and output
// back-pressure, and gives the verdict. Depends on imufps_pkg and imu_frame_parser_scaler_chk.
module imu_frame_parser_scaler_tb;
	import imufps_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SEG_BYTES   = 242;
	localparam int SEGMENTS    = 6;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [47:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic [31:0] prdata;
	logic        pready;

	int src_idle = 21;
	int dst_idle = 80;
	int n_sent   = 0;
	int quiet    = 0;
	int fails;
	int due;

	// broken run, sync run, then one frame of edge-case words
	logic [7:0] lead_in [0:40] = '{
		8'hFF, 8'hFF, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34,
		8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'h00, 8'h01, 8'h7F, 8'hFF,
		8'h80, 8'h00, 8'h12, 8'h34, 8'hFE, 8'hDC,
		8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hC3
	};

	imu_frame_parser_scaler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	imu_frame_parser_scaler_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.fail_cnt (fails),
		.due_cnt  (due)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= dst_idle);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("** imu_frame_parser_scaler: FAILED **");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h7F;
			3:       return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [19:0] g, input logic [19:0] a,
			input logic [19:0] m, input logic [19:0] t, input logic [23:0] o);
		reg_write(REG_GYRO_GAIN,   {12'($urandom), g});
		reg_write(REG_ACCEL_GAIN,  {12'($urandom), a});
		reg_write(REG_MAG_GAIN,    {12'($urandom), m});
		reg_write(REG_TEMP_GAIN,   {12'($urandom), t});
		reg_write(REG_TEMP_OFFSET, {8'($urandom), o});
		for (int k = int'(REG_TEMP_OFFSET) + 1; k < 8; k++)
			reg_write(3'(k), $urandom);
	endtask

	// drop the stream and hold until every expected result has been transferred
	task automatic settle();
		s_tvalid <= 1'b0;
		repeat (4) @(posedge clk);
		while (due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 41; i++)
			send_byte(lead_in[i]);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			case (seg / 2)
				0: begin
					src_idle = 21;
					dst_idle = 80;
				end
				1: begin
					src_idle = 80;
					dst_idle = 21;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			case (seg)
				0: ;
				1: program_regs('1, '1, '1, '1, 24'h7FFFFF);
				2: program_regs('0, '0, '0, '0, 24'h800000);
				default: program_regs(20'($urandom), 20'($urandom), 20'($urandom),
					20'($urandom), 24'($urandom));
			endcase
			while (n_sent < 41 + (seg + 1) * SEG_BYTES) begin
				if ($urandom_range(99) < 80) begin
					repeat ($urandom_range(0, 2)) send_byte(pick_byte());
					repeat (SYNC_RUN_LENGTH_DEF) send_byte(SYNC_BYTE);
					repeat (FRAME_BYTES_DEF) send_byte(pick_byte());
				end else if ($urandom_range(1)) begin
					repeat ($urandom_range(1, SYNC_RUN_LENGTH_DEF - 1)) send_byte(SYNC_BYTE);
					send_byte(8'($urandom_range(0, 254)));
				end else begin
					repeat ($urandom_range(1, 6)) send_byte(pick_byte());
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fails == 0 && due == 0)
			$display("** imu_frame_parser_scaler: PASSED **");
		else
			$display("** imu_frame_parser_scaler: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
src/imufps_pkg.sv
src/imu_frame_parser_scaler.sv
tb/imu_frame_parser_scaler_chk.sv
tb/imu_frame_parser_scaler_tb.sv
